### rtl/rtc_pkg.sv
// Shared types, constants and helpers for the run-length text codec.
// Used by the channel interfaces and every module of the codec; depends on nothing.
`default_nettype none

package rtc_pkg;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 7;
   localparam int TENS_W      = 4;
   localparam int MAX_RUN_DEF = 64;
   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_ADDR_W-1:0] REG_DECODE_MODE = CSR_ADDR_W'(0);

   localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;
   localparam int                RADIX   = 10;
   localparam int                MAX_TENS = 9;

   typedef enum logic [0:0] {
      JOB_RUNS,
      JOB_COPY
   } job_op_type;

   typedef enum logic [1:0] {
      PH_TENS,
      PH_ONES,
      PH_SYM,
      PH_COPY
   } phase_type;

   typedef struct packed {
      job_op_type              op;
      logic                    err;
      logic                    a_valid;
      logic [LEN_W-1:0]        a_len;
      logic [BYTE_W-1:0]       a_sym;
      logic                    b_valid;
      logic [LEN_W-1:0]        b_len;
      logic [BYTE_W-1:0]       b_sym;
   } job_type;

   function automatic logic [TENS_W-1:0] tens_of(input logic [LEN_W-1:0] len);
      logic [TENS_W-1:0] t;
      t = '0;
      for (int k = 1; k <= MAX_TENS; k++) begin
         if (len >= LEN_W'(k * RADIX)) begin
            t = TENS_W'(k);
         end
      end
      return t;
   endfunction

   function automatic logic [TENS_W-1:0] ones_of(input logic [LEN_W-1:0] len);
      logic [TENS_W-1:0] t;
      logic [LEN_W-1:0]  r;
      t = tens_of(len);
      r = len - ((LEN_W'(t) << 3) + (LEN_W'(t) << 1));
      return r[TENS_W-1:0];
   endfunction

endpackage

`default_nettype wire

### rtl/rtc_channels.sv
// Valid/ready channel interfaces for the codec's byte input and result output.
// Depends on rtc_pkg for field widths.
`default_nettype none

interface rtc_req_if;
   logic                        valid;
   logic                        ready;
   logic [rtc_pkg::BYTE_W-1:0]  data_byte;
   logic                        stream_last;

   modport source (output valid, data_byte, stream_last, input ready);
   modport sink   (input valid, data_byte, stream_last, output ready);
endinterface

interface rtc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rtc_pkg::BYTE_W-1:0]  out_byte;
   logic                        burst_last;
   logic                        count_error;

   modport source (output valid, out_byte, burst_last, count_error, input ready);
   modport sink   (input valid, out_byte, burst_last, count_error, output ready);
endinterface

`default_nettype wire

### rtl/rle_text_codec_unit.sv
// Top level of the run-length text codec: register port, front end, job queue, back end.
// Depends on rtc_pkg, rtc_channels, rtc_front, rtc_queue and rtc_back.
//
//   port       dir   handshake            payload
//   req_ch     in    valid/ready          data_byte, stream_last
//   rsp_ch     out   valid/ready          out_byte, burst_last, count_error
//   csr_*      in    APB write, pready=1  decode_mode at byte address 0
//
// Input bytes are taken one per cycle while the job queue has room.
// Each producing item becomes one job; the back end loads it, then gives one result per cycle
// while rsp_ch is not stalled: up to six for an encoded item, n for a decoded run of n.
// Results pass through an output register, so a stalled output fills the queue before
// the input stalls. Reset is synchronous and clears all control state.
`default_nettype none

module rle_text_codec_unit #(
   parameter int MAX_RUN     = rtc_pkg::MAX_RUN_DEF,
   parameter int QUEUE_DEPTH = rtc_pkg::QUEUE_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   rtc_req_if.sink                              req_ch,
   rtc_rsp_if.source                            rsp_ch,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [rtc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [rtc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [rtc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   logic             mode_ff;
   logic             mode_wr;
   logic             push;
   logic             pop;
   logic             queue_full;
   logic             queue_empty;
   rtc_pkg::job_type push_job;
   rtc_pkg::job_type head_job;

   assign csr_pready = 1'b1;
   assign mode_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr == rtc_pkg::REG_DECODE_MODE);
   assign csr_prdata = (csr_paddr == rtc_pkg::REG_DECODE_MODE) ?
                       rtc_pkg::CSR_DATA_W'(mode_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (mode_wr) begin
         mode_ff <= csr_pwdata[0];
      end
   end

   rtc_front #(
      .MAX_RUN (MAX_RUN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg_clear   (mode_wr),
      .decode_mode (mode_ff),
      .req_ch      (req_ch),
      .queue_full  (queue_full),
      .push        (push),
      .push_job    (push_job)
   );

   rtc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty)
   );

   rtc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp_ch      (rsp_ch)
   );

endmodule

`default_nettype wire

### rtl/rtc_front.sv
// Front end: accepts stream bytes, tracks the open run or the gathered count,
// and pushes one job per item that produces output. Depends on rtc_pkg, rtc_req_if.
`default_nettype none

module rtc_front #(
   parameter int MAX_RUN = rtc_pkg::MAX_RUN_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     cfg_clear,
   input  wire logic     decode_mode,
   rtc_req_if.sink       req_ch,
   input  wire logic     queue_full,
   output logic          push,
   output rtc_pkg::job_type push_job
);

   localparam int ACC_W = rtc_pkg::LEN_W + 4;

   logic [rtc_pkg::BYTE_W-1:0] held_ff, held_in;
   logic [rtc_pkg::LEN_W-1:0]  run_ff, run_in;
   logic                       have_ff, have_in;
   logic [rtc_pkg::LEN_W-1:0]  pend_ff, pend_in;
   logic                       seen_ff, seen_in;
   logic                       ovf_ff, ovf_in;

   logic                       accept;
   logic                       is_digit;
   logic [ACC_W-1:0]           acc;
   logic                       extend;
   logic [rtc_pkg::LEN_W-1:0]  new_len;
   logic [rtc_pkg::BYTE_W-1:0] new_sym;
   rtc_pkg::job_type           job;
   logic                       job_any;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && !queue_full;

   always_comb begin
      is_digit = (req_ch.data_byte >= rtc_pkg::CH_ZERO) &&
                 (req_ch.data_byte <= rtc_pkg::CH_NINE);
      acc = ACC_W'(pend_ff) * ACC_W'(rtc_pkg::RADIX) +
            ACC_W'(req_ch.data_byte - rtc_pkg::CH_ZERO);
      extend = have_ff && (req_ch.data_byte == held_ff) &&
               (run_ff < rtc_pkg::LEN_W'(MAX_RUN));
      new_len = extend ? run_ff + rtc_pkg::LEN_W'(1) : rtc_pkg::LEN_W'(1);
      new_sym = extend ? held_ff : req_ch.data_byte;

      job     = '0;
      job_any = 1'b0;
      held_in = held_ff;
      run_in  = run_ff;
      have_in = have_ff;
      pend_in = pend_ff;
      seen_in = seen_ff;
      ovf_in  = ovf_ff;

      if (!decode_mode) begin
         job.op      = rtc_pkg::JOB_RUNS;
         job.a_valid = have_ff && !extend;
         job.a_len   = run_ff;
         job.a_sym   = held_ff;
         job.b_valid = req_ch.stream_last;
         job.b_len   = new_len;
         job.b_sym   = new_sym;
         job_any     = job.a_valid || job.b_valid;
         held_in     = new_sym;
         run_in      = new_len;
         have_in     = 1'b1;
      end else if (is_digit) begin
         if (!ovf_ff) begin
            if (acc > ACC_W'(MAX_RUN)) begin
               ovf_in = 1'b1;
            end else begin
               pend_in = acc[rtc_pkg::LEN_W-1:0];
            end
         end
         seen_in = 1'b1;
      end else begin
         job.op    = rtc_pkg::JOB_COPY;
         job.err   = ovf_ff;
         job.a_len = ovf_ff ? rtc_pkg::LEN_W'(1) : pend_ff;
         job.a_sym = req_ch.data_byte;
         job_any   = seen_ff && (ovf_ff || (pend_ff != '0));
         pend_in   = '0;
         seen_in   = 1'b0;
         ovf_in    = 1'b0;
      end

      if (req_ch.stream_last) begin
         held_in = '0;
         run_in  = '0;
         have_in = 1'b0;
         pend_in = '0;
         seen_in = 1'b0;
         ovf_in  = 1'b0;
      end
   end

   assign push     = accept && job_any;
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset || cfg_clear) begin
         held_ff <= '0;
         run_ff  <= '0;
         have_ff <= 1'b0;
         pend_ff <= '0;
         seen_ff <= 1'b0;
         ovf_ff  <= 1'b0;
      end else if (accept) begin
         held_ff <= held_in;
         run_ff  <= run_in;
         have_ff <= have_in;
         pend_ff <= pend_in;
         seen_ff <= seen_in;
         ovf_ff  <= ovf_in;
      end
   end

endmodule

`default_nettype wire

### rtl/rtc_queue.sv
// Short job queue between the codec's front and back ends.
// Depends on rtc_pkg for the job type.
`default_nettype none

module rtc_queue #(
   parameter int DEPTH = rtc_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  rtc_pkg::job_type       push_job,
   output logic                   full,
   input  wire logic              pop,
   output rtc_pkg::job_type       head_job,
   output logic                   empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rtc_pkg::job_type   slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push;
   logic               do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### rtl/rtc_back.sv
// Back end: expands queued jobs into count digits, symbols and decoded copies, one
// result per cycle while not stalled, via an output register. Depends on rtc_pkg, rtc_rsp_if.
`default_nettype none

module rtc_back (
   input  wire logic        clock,
   input  wire logic        reset,
   input  rtc_pkg::job_type head_job,
   input  wire logic        queue_empty,
   output logic             pop,
   rtc_rsp_if.source        rsp_ch
);

   rtc_pkg::job_type            job_ff, job_in;
   logic                        busy_ff, busy_in;
   rtc_pkg::phase_type          phase_ff, phase_in;
   logic                        sel_b_ff, sel_b_in;
   logic [rtc_pkg::LEN_W-1:0]   cnt_ff, cnt_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rtc_pkg::BYTE_W-1:0]  byte_ff;
   logic                        last_ff;
   logic                        err_ff;

   logic                        out_load;
   logic [rtc_pkg::LEN_W-1:0]   cur_len;
   logic [rtc_pkg::BYTE_W-1:0]  cur_sym;
   logic [rtc_pkg::BYTE_W-1:0]  emit_byte;
   logic                        emit_last;
   logic                        emit_err;

   assign out_load = busy_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign pop      = !busy_ff && !queue_empty;

   always_comb begin
      cur_len   = sel_b_ff ? job_ff.b_len : job_ff.a_len;
      cur_sym   = sel_b_ff ? job_ff.b_sym : job_ff.a_sym;
      emit_byte = cur_sym;
      emit_last = 1'b0;
      emit_err  = 1'b0;
      case (phase_ff)
         rtc_pkg::PH_TENS: begin
            emit_byte = rtc_pkg::CH_ZERO + rtc_pkg::BYTE_W'(rtc_pkg::tens_of(cur_len));
         end
         rtc_pkg::PH_ONES: begin
            emit_byte = rtc_pkg::CH_ZERO + rtc_pkg::BYTE_W'(rtc_pkg::ones_of(cur_len));
         end
         rtc_pkg::PH_SYM: begin
            emit_last = sel_b_ff || !job_ff.b_valid;
         end
         rtc_pkg::PH_COPY: begin
            emit_byte = job_ff.a_sym;
            emit_err  = job_ff.err;
            emit_last = (cnt_ff == rtc_pkg::LEN_W'(1));
         end
         default: begin
            emit_last = 1'b1;
         end
      endcase
   end

   always_comb begin
      job_in   = job_ff;
      busy_in  = busy_ff;
      phase_in = phase_ff;
      sel_b_in = sel_b_ff;
      cnt_in   = cnt_ff;
      if (pop) begin
         job_in  = head_job;
         busy_in = 1'b1;
         cnt_in  = head_job.a_len;
         if (head_job.op == rtc_pkg::JOB_COPY) begin
            phase_in = rtc_pkg::PH_COPY;
            sel_b_in = 1'b0;
         end else if (head_job.a_valid) begin
            sel_b_in = 1'b0;
            phase_in = (head_job.a_len >= rtc_pkg::LEN_W'(rtc_pkg::RADIX)) ?
                       rtc_pkg::PH_TENS : rtc_pkg::PH_ONES;
         end else begin
            sel_b_in = 1'b1;
            phase_in = (head_job.b_len >= rtc_pkg::LEN_W'(rtc_pkg::RADIX)) ?
                       rtc_pkg::PH_TENS : rtc_pkg::PH_ONES;
         end
      end else if (out_load) begin
         case (phase_ff)
            rtc_pkg::PH_TENS: begin
               phase_in = rtc_pkg::PH_ONES;
            end
            rtc_pkg::PH_ONES: begin
               phase_in = rtc_pkg::PH_SYM;
            end
            rtc_pkg::PH_SYM: begin
               if (emit_last) begin
                  busy_in = 1'b0;
               end else begin
                  sel_b_in = 1'b1;
                  phase_in = (job_ff.b_len >= rtc_pkg::LEN_W'(rtc_pkg::RADIX)) ?
                             rtc_pkg::PH_TENS : rtc_pkg::PH_ONES;
               end
            end
            rtc_pkg::PH_COPY: begin
               cnt_in = cnt_ff - rtc_pkg::LEN_W'(1);
               if (emit_last) begin
                  busy_in = 1'b0;
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= rtc_pkg::PH_TENS;
         sel_b_ff     <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         sel_b_ff     <= sel_b_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (out_load) begin
         byte_ff <= emit_byte;
         last_ff <= emit_last;
         err_ff  <= emit_err;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_byte    = byte_ff;
   assign rsp_ch.burst_last  = last_ff;
   assign rsp_ch.count_error = err_ff;

   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && err_ff |-> last_ff)
      else $error("count error result not marked last");

   a_err_not_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && err_ff |-> (byte_ff < rtc_pkg::CH_ZERO) ||
                                  (byte_ff > rtc_pkg::CH_NINE))
      else $error("count error result carries a digit");

   a_copy_count_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff && (phase_ff == rtc_pkg::PH_COPY) |-> cnt_ff != '0)
      else $error("copy phase with zero count");

   a_job_end_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> rsp_valid_ff && last_ff)
      else $error("job ended without a last result");

endmodule

`default_nettype wire

### tb/sv/rtc_codec_checker.sv
// Result checker for the run-length text codec: follows the byte, result and register ports,
// works out the bytes each accepted item must produce and compares them in arrival order.
// Depends on rtc_pkg and the channel interfaces of rtc_channels.
module rtc_codec_checker #(
   parameter int MAX_RUN = rtc_pkg::MAX_RUN_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   rtc_req_if                              req_ch,
   rtc_rsp_if                              rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rtc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rtc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input  logic                            csr_pready,
   output int                              pending_results,
   output int                              error_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import rtc_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              burst_last;
      logic              count_error;
   } codec_result_type;

   codec_result_type   expected_bytes[$];
   int                 mismatches = 0;
   logic               decode_on;
   logic [BYTE_W-1:0]  run_sym;
   logic [LEN_W-1:0]   run_len;
   logic               run_open;
   logic [LEN_W-1:0]   count_acc;
   logic               count_started;
   logic               count_over;

   function automatic void clear_stream();
      run_sym       = '0;
      run_len       = '0;
      run_open      = 1'b0;
      count_acc     = '0;
      count_started = 1'b0;
      count_over    = 1'b0;
   endfunction

   function automatic void push_result(input logic [BYTE_W-1:0] b, input logic err);
      codec_result_type r;
      r.out_byte    = b;
      r.burst_last  = 1'b0;
      r.count_error = err;
      expected_bytes.push_back(r);
   endfunction

   function automatic void flush_run();
      int n;
      n = run_len;
      if (n >= RADIX) begin
         push_result(CH_ZERO + BYTE_W'(n / RADIX % RADIX), 1'b0);
      end
      push_result(CH_ZERO + BYTE_W'(n % RADIX), 1'b0);
      push_result(run_sym, 1'b0);
   endfunction

   function automatic void encode_byte(input logic [BYTE_W-1:0] b, input logic close);
      if (run_open && b == run_sym && int'(run_len) < MAX_RUN) begin
         run_len = run_len + 1'b1;
      end else begin
         if (run_open) begin
            flush_run();
         end
         run_sym  = b;
         run_len  = LEN_W'(1);
         run_open = 1'b1;
      end
      if (close) begin
         flush_run();
      end
   endfunction

   function automatic void decode_byte(input logic [BYTE_W-1:0] b);
      int n;
      if (b >= CH_ZERO && b <= CH_NINE) begin
         if (!count_over) begin
            n = int'(count_acc) * RADIX + int'(b - CH_ZERO);
            if (n > MAX_RUN) begin
               count_over = 1'b1;
            end else begin
               count_acc = LEN_W'(n);
            end
         end
         count_started = 1'b1;
      end else begin
         if (count_started) begin
            if (count_over) begin
               push_result(b, 1'b1);
            end else begin
               repeat (int'(count_acc)) push_result(b, 1'b0);
            end
         end
         count_acc     = '0;
         count_started = 1'b0;
         count_over    = 1'b0;
      end
   endfunction

   function automatic void predict_item(input logic [BYTE_W-1:0] b, input logic close);
      int               first;
      codec_result_type tail;
      first = expected_bytes.size();
      if (decode_on) begin
         decode_byte(b);
      end else begin
         encode_byte(b, close);
      end
      if (close) begin
         clear_stream();
      end
      if (expected_bytes.size() > first) begin
         tail = expected_bytes.pop_back();
         tail.burst_last = 1'b1;
         expected_bytes.push_back(tail);
      end
   endfunction

   function automatic void check_result();
      codec_result_type want;
      if (expected_bytes.size() == 0) begin
         $display("%0t: result byte %02h last %0b error %0b with nothing expected",
                  $time, rsp_ch.out_byte, rsp_ch.burst_last, rsp_ch.count_error);
         mismatches++;
      end else begin
         want = expected_bytes.pop_front();
         if (rsp_ch.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %02h, got %02h",
                     $time, want.out_byte, rsp_ch.out_byte);
            mismatches++;
         end
         if (rsp_ch.burst_last !== want.burst_last) begin
            $display("%0t: burst_last expected %0b, got %0b",
                     $time, want.burst_last, rsp_ch.burst_last);
            mismatches++;
         end
         if (rsp_ch.count_error !== want.count_error) begin
            $display("%0t: count_error expected %0b, got %0b",
                     $time, want.count_error, rsp_ch.count_error);
            mismatches++;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_bytes.delete();
         decode_on = 1'b0;
         clear_stream();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_result();
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == REG_DECODE_MODE) begin
            decode_on = csr_pwdata[0];
            clear_stream();
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_item(req_ch.data_byte, req_ch.stream_last);
         end
      end
      pending_results <= expected_bytes.size();
      error_count     <= mismatches;
   end

endmodule

### tb/sv/rle_text_codec_unit_test.sv
// Testbench top for the run-length text codec: clock, reset, byte stimulus, result stalls
// and mode writes; the verdict comes from the failure count of rtc_codec_checker.
// Depends on rtc_pkg, rtc_channels, rle_text_codec_unit and rtc_codec_checker.
module rle_text_codec_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rtc_pkg::*;

   localparam int LONG_HOLD   = 300;
   localparam int SETTLE      = 16;
   localparam int CYCLE_LIMIT = 4_000_000;

   typedef logic [BYTE_W-1:0] byte_q_type[$];

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;
   int                     pending_results;
   int                     error_count;
   int                     hold_req = 0;
   int                     cycle_count = 0;
   bit                     steady = 1'b0;

   rtc_req_if req_ch();
   rtc_rsp_if rsp_ch();

   rle_text_codec_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   rtc_codec_checker #(.MAX_RUN(MAX_RUN_DEF)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .pending_results (pending_results),
      .error_count     (error_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** rle_text_codec_unit: FAILED **");
         $finish;
      end
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [BYTE_W-1:0] symbol_byte();
      logic [BYTE_W-1:0] b;
      do begin
         b = BYTE_W'($urandom_range(0, 255));
      end while (b >= CH_ZERO && b <= CH_NINE);
      return b;
   endfunction

   function automatic byte_q_type decimal_text(input int value);
      byte_q_type text;
      if (value >= 100) begin
         text.push_back(CH_ZERO + BYTE_W'(value / 100));
      end
      if (value >= RADIX) begin
         text.push_back(CH_ZERO + BYTE_W'(value / RADIX % RADIX));
      end
      text.push_back(CH_ZERO + BYTE_W'(value % RADIX));
      return text;
   endfunction

   function automatic byte_q_type raw_runs(input int n_items);
      byte_q_type        text;
      logic [BYTE_W-1:0] sym;
      int                len;
      int                r;
      while (text.size() < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            sym = 8'h61 + BYTE_W'($urandom_range(0, 3));
         end else if (r < 75) begin
            sym = CH_ZERO + BYTE_W'($urandom_range(0, 9));
         end else begin
            sym = BYTE_W'($urandom_range(0, 255));
         end
         r = $urandom_range(0, 99);
         if (r < 70) begin
            len = $urandom_range(1, 4);
         end else if (r < 96) begin
            len = $urandom_range(5, 12);
         end else begin
            len = $urandom_range(MAX_RUN_DEF - 1, MAX_RUN_DEF + 1);
         end
         repeat (len) text.push_back(sym);
      end
      return text;
   endfunction

   function automatic byte_q_type coded_text(input int n_groups);
      byte_q_type text;
      int         count;
      int         r;
      repeat (n_groups) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               count = $urandom_range(0, 6);
            end else if (r < 85) begin
               count = $urandom_range(7, 20);
            end else begin
               count = $urandom_range(21, MAX_RUN_DEF);
            end
            if ($urandom_range(0, 9) == 0) begin
               text.push_back(CH_ZERO);
            end
            text = {text, decimal_text(count)};
            text.push_back(symbol_byte());
         end else if (r < 87) begin
            text = {text, decimal_text($urandom_range(MAX_RUN_DEF + 1, 999))};
            text.push_back(symbol_byte());
         end else begin
            text.push_back(BYTE_W'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(0, 5) == 0) begin
         text = {text, decimal_text($urandom_range(1, 99))};
      end
      return text;
   endfunction

   task automatic send_item(input logic [BYTE_W-1:0] b, input logic close);
      int gap;
      gap = steady ? 0 : gap_length();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.data_byte   <= b;
      req_ch.stream_last <= close;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_stream(input byte_q_type text, input logic close);
      foreach (text[i]) begin
         send_item(text[i], close && i == text.size() - 1);
      end
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= REG_DECODE_MODE;
      csr_pwdata  <= CSR_DATA_W'(mode);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin
      int stall_left;
      int served;
      int rx_cycle;
      stall_left   = 0;
      served       = 0;
      rx_cycle     = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (served != hold_req) begin
            served++;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ((rx_cycle / 400) % 3 != 2) begin
               stall_left = gap_length();
            end
         end
      end
   end

   initial begin
      byte_q_type text;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.data_byte   = '0;
      req_ch.stream_last = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_mode(1'b0);
      send_item(8'h00, 1'b1);
      repeat (3) send_item(8'hFF, 1'b0);
      send_item(CH_ZERO + 8'd7, 1'b0);
      send_item(8'h80, 1'b1);
      text = {};
      repeat (10) text.push_back(8'h41);
      send_stream(text, 1'b1);
      send_item(8'h51, 1'b0);
      send_item(8'h51, 1'b0);
      wait_idle();

      write_mode(1'b1);
      text = {};
      text = {text, decimal_text(0)};
      text.push_back(8'h41);
      text = {text, decimal_text(64)};
      text.push_back(8'h43);
      text = {text, decimal_text(65)};
      text.push_back(8'h44);
      text = {text, decimal_text(999)};
      text.push_back(8'h45);
      text.push_back(8'h58);
      text = {text, decimal_text(3)};
      send_stream(text, 1'b1);
      text = {};
      text = {text, decimal_text(2)};
      text.push_back(8'hFF);
      send_stream(text, 1'b1);
      wait_idle();

      write_mode(1'b0);
      repeat (3) send_stream(raw_runs(12), 1'b1);
      text = {};
      repeat (MAX_RUN_DEF + 2) text.push_back(8'h5A);
      text.push_back(8'hA5);
      send_stream(text, 1'b1);
      wait_idle();

      write_mode(1'b1);
      hold_req <= hold_req + 1;
      repeat (3) send_stream(coded_text(5), 1'b1);
      wait_idle();
      repeat (3) send_stream(coded_text(5), 1'b1);
      wait_idle();

      write_mode(1'b0);
      steady = 1'b1;
      repeat (3) send_stream(raw_runs(10), 1'b1);
      steady = 1'b0;
      send_stream(raw_runs(8), 1'b1);
      wait_idle();

      if (error_count == 0) begin
         $display("** rle_text_codec_unit: PASSED **");
      end else begin
         $display("** rle_text_codec_unit: FAILED **");
      end
      $finish;
   end

endmodule
